// ===== hdl/pulse_period_speed_meter_defines.svh =====
// Assertion macros for the pulse period speed meter.
`ifndef PULSE_PERIOD_SPEED_METER_DEFINES_SVH
`define PULSE_PERIOD_SPEED_METER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PPSM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PPSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ppsm_pkg.sv =====
// Shared constants for the pulse period speed meter.
package ppsm_pkg;

  localparam int unsigned TIMER_WIDTH_DEF = 16;
  localparam int unsigned INTERVALS_DEF   = 4;

  localparam int unsigned CAPTURE_W  = 16;
  localparam int unsigned RATE_W     = 16;
  localparam int unsigned SPEED_W    = 16;
  localparam int unsigned AVG_OUT_W  = 14;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  // Unit scaling: speed = q * SCALE_x / SCALE_DIVISOR
  localparam int unsigned SCALE_W       = 11;
  localparam int unsigned SCALE_BASE    = 1000;
  localparam int unsigned SCALE_ALT     = 1609;
  localparam int unsigned SCALE_DIVISOR = 447;
  localparam int unsigned PROD_W        = RATE_W + SCALE_W;

  localparam int unsigned RATE_RESET = 16000;
  localparam logic        UNIT_RESET = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RATE_NUMERATOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_MODE      = 2'd1;

endpackage

// ===== hdl/ppsm_accum.sv =====
// Interval accumulator: phase counter, previous capture and running sum.
module ppsm_accum #(
  parameter int unsigned TIMER_WIDTH = ppsm_pkg::TIMER_WIDTH_DEF,
  parameter int unsigned INTERVALS   = ppsm_pkg::INTERVALS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [TIMER_WIDTH-1:0] capture_i,
  output logic                   group_done_o,
  output logic [TIMER_WIDTH-1:0] total_o
);
  import ppsm_pkg::*;

  localparam int unsigned PhW = $clog2(INTERVALS + 1);

  logic [PhW-1:0]         phase_q, phase_d;
  logic [TIMER_WIDTH-1:0] prev_q, prev_d;
  logic [TIMER_WIDTH-1:0] sum_q, sum_d;
  logic [TIMER_WIDTH-1:0] total_q, total_d;
  logic                   done_q, done_d;
  logic [TIMER_WIDTH-1:0] diff;

  assign diff = capture_i - prev_q;

  always_comb begin
    phase_d = phase_q;
    prev_d  = prev_q;
    sum_d   = sum_q;
    total_d = total_q;
    done_d  = done_q;
    if (step_i) begin
      if (phase_q == '0) begin
        prev_d  = capture_i;
        phase_d = PhW'(1);
        done_d  = 1'b0;
      end else if (phase_q >= PhW'(INTERVALS)) begin
        // close the group: keep prev, hand the total on, clear
        total_d = sum_q + diff;
        sum_d   = '0;
        phase_d = '0;
        done_d  = 1'b1;
      end else begin
        prev_d  = capture_i;
        sum_d   = sum_q + diff;
        phase_d = phase_q + PhW'(1);
        done_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      prev_q  <= '0;
      sum_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      prev_q  <= prev_d;
      sum_q   <= sum_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    total_q <= total_d;
  end

  assign group_done_o = done_q;
  assign total_o      = total_q;

endmodule

// ===== hdl/ppsm_divider.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module ppsm_divider #(
  parameter int unsigned WIDTH = ppsm_pkg::PROD_W
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [$clog2(WIDTH+1)-1:0] n_bits_i,
  input  logic [WIDTH-1:0]           dividend_i,
  input  logic [WIDTH-1:0]           divisor_i,
  output logic                       done_o,
  output logic [WIDTH-1:0]           quotient_o
);
  import ppsm_pkg::*;

  localparam int unsigned CntW = $clog2(WIDTH + 1);

  // dividend_i is left-aligned; after n_bits_i shifts the quotient fills dq_q
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] dq_q, dq_d;
  logic [WIDTH-1:0] dvs_q, dvs_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   trial_sub;
  logic             fits;

  assign trial     = {rem_q, dq_q[WIDTH-1]};
  assign trial_sub = trial - {1'b0, dvs_q};
  assign fits      = trial >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    dq_d   = dq_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      dq_d   = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = n_bits_i;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? trial_sub[WIDTH-1:0] : trial[WIDTH-1:0];
      dq_d  = {dq_q[WIDTH-2:0], fits};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dq_q  <= dq_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

// ===== hdl/pulse_period_speed_meter.sv =====
// Top level of the pulse period speed meter: sequencer, registers and outputs.
//
// Each accepted item is one timer capture of a sensor edge. Captures are
// grouped: the first of a group is stored, the next INTERVALS differences
// (modulo 2^TIMER_WIDTH) are summed, and when the group closes the average
// period becomes sum / INTERVALS. Every item returns one result: the speed
// derived from the current average period, floor(q*1000/447) with unit_mode
// set or floor(q*1609/447) with it clear, where q = rate_numerator / average,
// saturated at 65535 and 0 when the average is 0, together with the low 14
// bits of the average period. All division runs through one bit-serial
// restoring divider (one quotient bit per clock). An item that closes a
// group first divides the sum by INTERVALS; then q and the scaled speed
// are divided in turn, and both of these are skipped when the average is
// 0. One item is in work at a time; the result sits in an output
// register, so the next item is accepted while the previous result still
// waits to be taken.
// Configuration writes take effect at once and are meant for idle periods.

`include "pulse_period_speed_meter_defines.svh"

module pulse_period_speed_meter #(
  parameter int unsigned TIMER_WIDTH = ppsm_pkg::TIMER_WIDTH_DEF,
  parameter int unsigned INTERVALS   = ppsm_pkg::INTERVALS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [ppsm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ppsm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // capture items
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [ppsm_pkg::CAPTURE_W-1:0]  capture_time_i,
  // result items
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ppsm_pkg::SPEED_W-1:0]    speed_value_o,
  output logic [ppsm_pkg::AVG_OUT_W-1:0]  average_period_o
);
  import ppsm_pkg::*;

  localparam int unsigned DivW = (TIMER_WIDTH > PROD_W) ? TIMER_WIDTH : PROD_W;
  localparam int unsigned CntW = $clog2(DivW + 1);

  // sequencer codes
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_START  = 3'd1;
  localparam logic [2:0] ST_AVG    = 3'd2;
  localparam logic [2:0] ST_PREP   = 3'd3;
  localparam logic [2:0] ST_QUOT   = 3'd4;
  localparam logic [2:0] ST_SCALE  = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  logic [2:0]             state_q, state_d;
  logic [RATE_W-1:0]      rate_q;
  logic                   unit_q;
  logic [TIMER_WIDTH-1:0] avg_q, avg_d;
  logic [SPEED_W-1:0]     speed_q, speed_d;
  logic                   out_valid_q, out_valid_d;
  logic [SPEED_W-1:0]     out_speed_q, out_speed_d;
  logic [AVG_OUT_W-1:0]   out_avg_q, out_avg_d;

  logic                   in_accept;
  logic                   out_free;
  logic [TIMER_WIDTH-1:0] capture_tw;
  logic [TIMER_WIDTH+CAPTURE_W-1:0] capture_ext;
  logic [TIMER_WIDTH+AVG_OUT_W-1:0] avg_ext;
  logic                   group_done;
  logic [TIMER_WIDTH-1:0] group_total;

  logic                   div_start;
  logic [CntW-1:0]        div_n;
  logic [DivW-1:0]        div_dividend;
  logic [DivW-1:0]        div_divisor;
  logic                   div_done;
  logic [DivW-1:0]        div_quot;

  logic [SCALE_W-1:0]     scale_k;
  logic [PROD_W-1:0]      product;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // resize the capture to the timer width (drop or zero-fill upper bits)
  assign capture_ext = {{TIMER_WIDTH{1'b0}}, capture_time_i};
  assign capture_tw  = capture_ext[TIMER_WIDTH-1:0];
  assign avg_ext     = {{AVG_OUT_W{1'b0}}, avg_q};

  // configuration registers; out-of-range indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RATE_W'(RATE_RESET);
      unit_q <= UNIT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_RATE_NUMERATOR: rate_q <= cfg_data_i[RATE_W-1:0];
        REG_UNIT_MODE:      unit_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  ppsm_accum #(
    .TIMER_WIDTH (TIMER_WIDTH),
    .INTERVALS   (INTERVALS)
  ) u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (in_accept),
    .capture_i    (capture_tw),
    .group_done_o (group_done),
    .total_o      (group_total)
  );

  ppsm_divider #(
    .WIDTH (DivW)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .n_bits_i   (div_n),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // q fits in RATE_W bits since the average is at least 1
  assign scale_k = unit_q ? SCALE_W'(SCALE_BASE) : SCALE_W'(SCALE_ALT);
  assign product = PROD_W'(div_quot[RATE_W-1:0]) * PROD_W'(scale_k);

  always_comb begin
    state_d      = state_q;
    avg_d        = avg_q;
    speed_d      = speed_q;
    out_valid_d  = out_valid_q;
    out_speed_d  = out_speed_q;
    out_avg_d    = out_avg_q;
    div_start    = 1'b0;
    div_n        = CntW'(TIMER_WIDTH);
    div_dividend = DivW'(group_total) << (DivW - TIMER_WIDTH);
    div_divisor  = DivW'(INTERVALS);

    // drop the result once the consumer takes it
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        // a closed group needs its average first
        if (group_done) begin
          div_start = 1'b1;
          state_d   = ST_AVG;
        end else begin
          state_d = ST_PREP;
        end
      end
      ST_AVG: begin
        if (div_done) begin
          avg_d   = div_quot[TIMER_WIDTH-1:0];
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        if (avg_q == '0) begin
          speed_d = '0;
          state_d = ST_FINISH;
        end else begin
          div_start    = 1'b1;
          div_n        = CntW'(RATE_W);
          div_dividend = DivW'(rate_q) << (DivW - RATE_W);
          div_divisor  = DivW'(avg_q);
          state_d      = ST_QUOT;
        end
      end
      ST_QUOT: begin
        // scale q by the unit constant and divide by SCALE_DIVISOR in one go
        if (div_done) begin
          div_start    = 1'b1;
          div_n        = CntW'(PROD_W);
          div_dividend = DivW'(product) << (DivW - PROD_W);
          div_divisor  = DivW'(SCALE_DIVISOR);
          state_d      = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (div_done) begin
          speed_d = (|div_quot[DivW-1:SPEED_W]) ? '1 : div_quot[SPEED_W-1:0];
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_d = 1'b1;
          out_speed_d = speed_q;
          out_avg_d   = avg_ext[AVG_OUT_W-1:0];
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      avg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      avg_q       <= avg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    speed_q     <= speed_d;
    out_speed_q <= out_speed_d;
    out_avg_q   <= out_avg_d;
  end

  assign out_valid_o      = out_valid_q;
  assign speed_value_o    = out_speed_q;
  assign average_period_o = out_avg_q;

  // an accepted item always starts the sequence
  `PPSM_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, in_accept, state_q == ST_START, "accepted item did not start the sequence")
  // a finished result lands in a free output register
  `PPSM_ASSERT_NEXT(a_finish_delivers, clk_i, rst_ni, (state_q == ST_FINISH) && out_free, out_valid_o && (state_q == ST_IDLE), "finished result not presented")
  // the divider only reports while a division is awaited
  `PPSM_ASSERT_NOW(a_div_done_expected, clk_i, rst_ni, div_done, (state_q == ST_AVG) || (state_q == ST_QUOT) || (state_q == ST_SCALE), "divider finished outside a division state")

endmodule

// ===== bench/pulse_period_speed_meter_tb.sv =====
// Self-checking testbench for the pulse period speed meter.
module pulse_period_speed_meter_tb;
  import ppsm_pkg::*;

  // Run guard and drain allowances.
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES   = 150;
  localparam int unsigned SINK_HOLD     = 400;

  // Register indexes past the end of the map: writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef enum int unsigned {SINK_OPEN, SINK_RANDOM, SINK_CHOKED} sink_mode_e;

  // Tracks the tachometer state and the readings it owes, in arrival order.
  class speed_scoreboard;
    typedef struct {
      logic [SPEED_W-1:0]   speed;
      logic [AVG_OUT_W-1:0] avg;
      int unsigned          item;
    } reading_t;

    reading_t             expected_q[$];
    logic [RATE_W-1:0]    rate;
    logic                 unit_is_base;
    int unsigned          phase;
    logic [CAPTURE_W-1:0] last_capture;
    logic [CAPTURE_W-1:0] tick_sum;
    logic [CAPTURE_W-1:0] mean_ticks;
    int unsigned          captures;
    int unsigned          readings;
    int unsigned          errors;

    function new();
      rate         = RATE_W'(RATE_RESET);
      unit_is_base = UNIT_RESET;
      phase        = 0;
      last_capture = '0;
      tick_sum     = '0;
      mean_ticks   = '0;
      captures     = 0;
      readings     = 0;
      errors       = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_RATE_NUMERATOR: rate = data[RATE_W-1:0];
        REG_UNIT_MODE:      unit_is_base = data[0];
        default: ;
      endcase
    endfunction

    function logic [SPEED_W-1:0] speed_for(logic [CAPTURE_W-1:0] ticks);
      longint unsigned quot;
      longint unsigned scaled;
      if (ticks == '0) return '0;
      quot   = 64'(rate) / 64'(ticks);
      scaled = quot * 64'(unit_is_base ? SCALE_BASE : SCALE_ALT) / 64'(SCALE_DIVISOR);
      if ((scaled >> SPEED_W) != 0) return '1;
      return scaled[SPEED_W-1:0];
    endfunction

    // Advance the interval accumulator by one capture and queue the reading.
    function void note_capture(logic [CAPTURE_W-1:0] cap);
      logic [CAPTURE_W-1:0] delta;
      reading_t             r;
      delta = cap - last_capture;
      if (phase == 0) begin
        last_capture = cap;
        phase        = 1;
      end else if (phase >= INTERVALS_DEF) begin
        tick_sum   = tick_sum + delta;
        mean_ticks = CAPTURE_W'(tick_sum / INTERVALS_DEF);
        tick_sum   = '0;
        phase      = 0;
      end else begin
        tick_sum     = tick_sum + delta;
        last_capture = cap;
        phase++;
      end
      r.speed = speed_for(mean_ticks);
      r.avg   = mean_ticks[AVG_OUT_W-1:0];
      r.item  = captures;
      captures++;
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(logic [SPEED_W-1:0] speed, logic [AVG_OUT_W-1:0] avg);
      reading_t want;
      readings++;
      if (expected_q.size() == 0) begin
        report($sformatf("reading speed=%0d avg=%0d with no capture pending", speed, avg));
        return;
      end
      want = expected_q.pop_front();
      if (speed !== want.speed)
        report($sformatf("item %0d speed_value got %0d want %0d", want.item, speed, want.speed));
      if (avg !== want.avg)
        report($sformatf("item %0d average_period got %0d want %0d", want.item, avg,
                         want.avg));
    endtask
  endclass

  // Clock, reset and every block input start at known values.
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_valid   = 1'b0;
  logic [CAPTURE_W-1:0]  capture_time = '0;
  logic                  out_ready  = 1'b0;

  logic                  in_ready;
  logic                  out_valid;
  logic [SPEED_W-1:0]    speed_value;
  logic [AVG_OUT_W-1:0]  average_period;

  speed_scoreboard       sb = new();
  int unsigned           cycle_count = 0;
  int unsigned           burst_left = 0;
  logic [CAPTURE_W-1:0]  capture_cursor = '0;

  pulse_period_speed_meter dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .capture_time_i   (capture_time),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .speed_value_o    (speed_value),
    .average_period_o (average_period)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("pulse_period_speed_meter_tb: FAIL");
      $finish;
    end
  end

  // Result side. Sample on the edge, then pick ready for the next cycle.
  // The stall pattern switches between always ready, coin flip and mostly
  // stalled. Twice the sink closes for a long stretch so that the block
  // fills up and pushes back on the capture side.
  initial begin : result_sink
    sink_mode_e  mode;
    int unsigned mode_left;
    int unsigned holds_done;
    mode       = SINK_OPEN;
    mode_left  = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_result(speed_value, average_period);
      if ((holds_done == 0 && sb.readings >= 300) || (holds_done == 1 && sb.readings >= 1000))
      begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (SINK_HOLD) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode      = sink_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (mode)
        SINK_OPEN:   out_ready <= 1'b1;
        SINK_RANDOM: out_ready <= 1'($urandom_range(0, 1));
        default:     out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Lower valid, then hold the capture side until every reading has come.
  // Always advance at least one edge so valid is not driven twice in a step.
  task automatic wait_drained();
    if (in_valid) in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Burst pacing: after a burst of random length, drop valid for a gap.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left != 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1:       gap = $urandom_range(1, 3);
        2:       gap = $urandom_range(4, 20);
        default: gap = $urandom_range(20, 80);
      endcase
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Offer one capture and hold it until the block takes it.
  task automatic send_capture(input logic [CAPTURE_W-1:0] cap);
    in_valid     <= 1'b1;
    capture_time <= cap;
    do @(posedge clk); while (!in_ready);
    sb.note_capture(cap);
    pace_sender();
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_register(idx, data);
  endtask

  // Reprogram only with the block idle. Hit the unmapped indexes first, so
  // any aliasing onto a real register is overwritten by the later writes.
  // Unit mode carries junk in its upper data bits; only bit 0 counts.
  task automatic reconfigure(input logic [CFG_DATA_W-1:0] rate, input logic unit);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
    write_reg(REG_RATE_NUMERATOR, rate);
    write_reg(REG_UNIT_MODE, {junk[CFG_DATA_W-1:1], unit});
    cfg_we <= 1'b0;
  endtask

  // Mostly forward-moving timestamps with short, medium and long intervals
  // (long ones wrap the 16-bit sum), plus some fully random jumps as noise.
  function automatic logic [CAPTURE_W-1:0] next_capture();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 10)      capture_cursor = CAPTURE_W'($urandom);
    else if (pick < 40) capture_cursor = capture_cursor + CAPTURE_W'($urandom_range(0, 8));
    else if (pick < 75) capture_cursor = capture_cursor + CAPTURE_W'($urandom_range(0, 400));
    else if (pick < 95) capture_cursor = capture_cursor + CAPTURE_W'($urandom_range(0, 5000));
    else                capture_cursor = capture_cursor + CAPTURE_W'($urandom_range(0, 20000));
    return capture_cursor;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_rate();
    if ($urandom_range(0, 3) == 0) return CFG_DATA_W'($urandom_range(1, 255));
    return CFG_DATA_W'($urandom_range(1, 65535));
  endfunction

  // Random captures; halfway through, pause until the block runs dry.
  task automatic random_captures(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i == count / 2) wait_drained();
      send_capture(next_capture());
    end
  endtask

  initial begin : stimulus
    logic [CAPTURE_W-1:0] directed_caps[$];
    // Groups of five: unit intervals (average 1), wrapping timestamps with
    // all bits high, a mid-size average, and equal timestamps that bring the
    // average back to zero. The very first reading sees a zero average.
    directed_caps = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4,
                      16'hFFFF, 16'd3, 16'hFFFF, 16'd9, 16'hFFFD,
                      16'd0, 16'd1000, 16'd2000, 16'd3000, 16'd4000,
                      16'd5, 16'd5, 16'd5, 16'd5, 16'd5};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_caps[i]) send_capture(directed_caps[i]);

    // Largest numerator over a one-tick average in the wider unit: saturate.
    reconfigure(16'hFFFF, 1'b0);
    for (int unsigned i = 0; i < 5; i++) send_capture(CAPTURE_W'(i));
    random_captures(300);

    // Zero numerator, then the smallest one, then back to the reset values.
    reconfigure(16'd0, 1'b1);
    random_captures(100);
    reconfigure(16'd1, 1'b0);
    random_captures(150);
    reconfigure(CFG_DATA_W'(RATE_RESET), UNIT_RESET);
    random_captures(250);

    repeat (3) begin
      reconfigure(random_rate(), 1'($urandom_range(0, 1)));
      random_captures(230);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d readings never arrived", sb.pending()));

    if (sb.errors == 0) begin
      $display("pulse_period_speed_meter_tb: PASS");
    end else begin
      $display("pulse_period_speed_meter_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/ppsm_pkg.sv
hdl/ppsm_accum.sv
hdl/ppsm_divider.sv
hdl/pulse_period_speed_meter.sv
bench/pulse_period_speed_meter_tb.sv
